@@ rtl/nfa2dfa_pkg.sv @@
// shared constants and codes for the nfa to dfa subset builder
`default_nettype none
package nfa2dfa_pkg;

  localparam int NFA_STATES_DEF = 8;
  localparam int SYMBOLS_DEF = 8;
  localparam int DFA_STATES_DEF = 256;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_NFA_STATE_COUNT = 2'd0,
    REG_SYMBOL_COUNT    = 2'd1,
    REG_FINAL_MASK      = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_idx_t;

  localparam logic [3:0] NFA_STATE_COUNT_RST = 4'd8;
  localparam logic [3:0] SYMBOL_COUNT_RST = 4'd8;
  localparam logic [7:0] FINAL_MASK_RST = 8'd0;

endpackage
`default_nettype wire

@@ rtl/nfa_to_dfa_subset_builder.sv @@
// top level of the nfa to dfa subset builder with its sequencer and stores
//
// input channel (in_valid/in_ready) carries one item: load an nfa row,
// build the dfa, or read one dfa entry. every item gives exactly one
// result on the output channel (out_valid/out_ready).
// a load registers its result in the cycle after the transfer; a read
// passes S_READ and S_RDOUT first. a build runs a sequencer over one
// shared union/compare datapath: per dfa state S_FETCH and S_CUR fetch
// its subset, then per symbol an S_UNI/S_ACC pair per nfa state forms the
// union over the nfa table port, S_EVAL checks it, S_SREAD/S_SCMP search
// the known subsets over the subset store port with one more S_SREAD when
// the subset is new, and S_NSYM steps on; an empty union or a symbol past the symbol count skips the search.
// in_ready is low while an item is at work, and high in idle once the
// output register is free or is being emptied in the same cycle.
// when the receiver stalls the result is held in the output register.
// reset clears the nfa table through per entry valid bits, the dfa
// count and the registers (state count 8, symbol count 8, final mask 0).
// the user must write registers over the apb port only while the block is idle; the block does not enforce it.
`default_nettype none
module nfa_to_dfa_subset_builder #(
  parameter int NFA_STATES = nfa2dfa_pkg::NFA_STATES_DEF,
  parameter int SYMBOLS = nfa2dfa_pkg::SYMBOLS_DEF,
  parameter int DFA_STATES = nfa2dfa_pkg::DFA_STATES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_operation,
  input  wire logic [2:0]                        in_from_state,
  input  wire logic [2:0]                        in_symbol,
  input  wire logic [7:0]                        in_target_set,
  input  wire logic [7:0]                        in_dfa_index,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_status,
  output logic [8:0]                             out_state_count,
  output logic                                   out_next_valid,
  output logic [7:0]                             out_next_index,
  output logic [7:0]                             out_subset_mask,
  output logic                                   out_is_final,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [nfa2dfa_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [nfa2dfa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nfa2dfa_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                   pready
);

  localparam int SW = NFA_STATES;
  localparam int NE = NFA_STATES * SYMBOLS;
  localparam int NA = $clog2(NE);
  localparam int DW = $clog2(DFA_STATES);
  localparam int CW = DW + 1;
  localparam int XE = DFA_STATES * SYMBOLS;
  localparam int XA = $clog2(XE);
  localparam int SB = $clog2(NFA_STATES);
  localparam int YB = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_READ  = 13'b0000000000010,
    S_RDOUT = 13'b0000000000100,
    S_INIT  = 13'b0000000001000,
    S_FETCH = 13'b0000000010000,
    S_CUR   = 13'b0000000100000,
    S_UNI   = 13'b0000001000000,
    S_ACC   = 13'b0000010000000,
    S_EVAL  = 13'b0000100000000,
    S_SREAD = 13'b0001000000000,
    S_SCMP  = 13'b0010000000000,
    S_NSYM  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  // configuration registers
  logic [3:0] nsc_r, ssc_r;
  logic [7:0] fmask_r;
  logic       cfg_wr;
  nfa2dfa_pkg::reg_idx_t cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = nfa2dfa_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsc_r <= nfa2dfa_pkg::NFA_STATE_COUNT_RST;
      ssc_r <= nfa2dfa_pkg::SYMBOL_COUNT_RST;
      fmask_r <= nfa2dfa_pkg::FINAL_MASK_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        nfa2dfa_pkg::REG_NFA_STATE_COUNT: nsc_r <= pwdata[3:0];
        nfa2dfa_pkg::REG_SYMBOL_COUNT:    ssc_r <= pwdata[3:0];
        nfa2dfa_pkg::REG_FINAL_MASK:      fmask_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      nfa2dfa_pkg::REG_NFA_STATE_COUNT: prdata = 32'(nsc_r);
      nfa2dfa_pkg::REG_SYMBOL_COUNT:    prdata = 32'(ssc_r);
      nfa2dfa_pkg::REG_FINAL_MASK:      prdata = 32'(fmask_r);
      default:                          prdata = '0;
    endcase
  end

  // effective counts and masks
  logic [31:0]   ns, nsym;
  logic [SW-1:0] act, fm_ext;

  assign ns = (32'(nsc_r) > 32'(NFA_STATES)) ? 32'(NFA_STATES) : 32'(nsc_r);
  assign nsym = (32'(ssc_r) > 32'(SYMBOLS)) ? 32'(SYMBOLS) : 32'(ssc_r);
  assign fm_ext = SW'(fmask_r);

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      act[i] = (32'(i) < ns);
    end
  end

  // stores
  logic [SW-1:0] nfa_mem [NE];
  logic          nfa_vld_r [NE];
  logic          nfa_we;
  logic [NA-1:0] nfa_waddr, nfa_raddr;
  logic [SW-1:0] nfa_wdata, nfa_rdata_r;
  logic          nfa_rvld_r;

  logic [SW:0]   sub_mem [DFA_STATES];
  logic          sub_we;
  logic [DW-1:0] sub_waddr, sub_raddr;
  logic [SW:0]   sub_wdata, sub_rdata_r;

  logic [DW:0]   nxt_mem [XE];
  logic          nxt_we;
  logic [XA-1:0] nxt_waddr, nxt_raddr;
  logic [DW:0]   nxt_wdata, nxt_rdata_r;

  always_ff @(posedge clk) begin
    if (nfa_we) nfa_mem[nfa_waddr] <= nfa_wdata;
    nfa_rdata_r <= nfa_mem[nfa_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NE; i++) nfa_vld_r[i] <= 1'b0;
      nfa_rvld_r <= 1'b0;
    end else begin
      if (nfa_we) nfa_vld_r[nfa_waddr] <= 1'b1;
      nfa_rvld_r <= nfa_vld_r[nfa_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sub_we) sub_mem[sub_waddr] <= sub_wdata;
    sub_rdata_r <= sub_mem[sub_raddr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    nxt_rdata_r <= nxt_mem[nxt_raddr];
  end

  // sequencer
  state_t        state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [2:0]    sym_in_r, sym_in_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt, wp_r, wp_nxt, k_r, k_nxt;
  logic [SW-1:0] cur_r, cur_nxt, uni_r, uni_nxt;
  logic [SB-1:0] st_r, st_nxt;
  logic [YB-1:0] sym_r, sym_nxt;
  logic          ov_r, ov_nxt;
  logic          o_status_r, o_status_nxt, o_nv_r, o_nv_nxt, o_fin_r, o_fin_nxt;
  logic [7:0]    o_ni_r, o_ni_nxt, o_sm_r, o_sm_nxt;
  logic          acc;
  logic [SW-1:0] uni_m;
  logic [XA-1:0] wp_addr;

  assign in_ready = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign acc = in_valid && in_ready;
  assign uni_m = uni_r & act;
  assign wp_addr = XA'(32'(wp_r) * SYMBOLS + 32'(sym_r));

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    sym_in_nxt = sym_in_r;
    idx_nxt = idx_r;
    count_nxt = count_r;
    wp_nxt = wp_r;
    k_nxt = k_r;
    cur_nxt = cur_r;
    uni_nxt = uni_r;
    st_nxt = st_r;
    sym_nxt = sym_r;
    ov_nxt = ov_r && !out_ready;
    o_status_nxt = o_status_r;
    o_nv_nxt = o_nv_r;
    o_fin_nxt = o_fin_r;
    o_ni_nxt = o_ni_r;
    o_sm_nxt = o_sm_r;
    nfa_we = 1'b0;
    nfa_waddr = NA'(32'(in_from_state) * SYMBOLS + 32'(in_symbol));
    nfa_wdata = SW'(in_target_set);
    nfa_raddr = NA'(32'(st_r) * SYMBOLS + 32'(sym_r));
    sub_we = 1'b0;
    sub_waddr = count_r[DW-1:0];
    sub_wdata = {(uni_m & fm_ext & act) != '0, uni_m};
    sub_raddr = k_r[DW-1:0];
    nxt_we = 1'b0;
    nxt_waddr = wp_addr;
    nxt_wdata = '0;
    nxt_raddr = XA'(32'(DW'(idx_r)) * SYMBOLS + 32'(sym_in_r));
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt = in_operation;
          sym_in_nxt = in_symbol;
          idx_nxt = in_dfa_index;
          o_status_nxt = 1'b0;
          o_nv_nxt = 1'b0;
          o_ni_nxt = '0;
          o_sm_nxt = '0;
          o_fin_nxt = 1'b0;
          case (nfa2dfa_pkg::op_t'(in_operation))
            nfa2dfa_pkg::OP_BUILD: begin
              ov_nxt = 1'b0;
              state_nxt = S_INIT;
            end
            nfa2dfa_pkg::OP_READ: begin
              ov_nxt = 1'b0;
              state_nxt = S_READ;
            end
            nfa2dfa_pkg::OP_LOAD: begin
              nfa_we = (32'(in_from_state) < 32'(NFA_STATES)) &&
                       (32'(in_symbol) < 32'(SYMBOLS));
              ov_nxt = 1'b1;
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_READ: begin
        sub_raddr = DW'(idx_r);
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        if (32'(idx_r) >= 32'(count_r)) begin
          o_status_nxt = 1'b1;
        end else begin
          if (32'(sym_in_r) < nsym && nxt_rdata_r[DW]) begin
            o_nv_nxt = 1'b1;
            o_ni_nxt = 8'(nxt_rdata_r[DW-1:0]);
          end
          o_sm_nxt = 8'(sub_rdata_r[SW-1:0]);
          o_fin_nxt = sub_rdata_r[SW];
        end
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        sub_we = 1'b1;
        sub_waddr = '0;
        sub_wdata = {(SW'(1) & fm_ext & act) != '0, SW'(1)};
        count_nxt = CW'(1);
        wp_nxt = '0;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        sub_raddr = wp_r[DW-1:0];
        state_nxt = (wp_r == count_r) ? S_DONE : S_CUR;
      end
      S_CUR: begin
        cur_nxt = sub_rdata_r[SW-1:0];
        sym_nxt = '0;
        st_nxt = '0;
        uni_nxt = '0;
        state_nxt = S_UNI;
      end
      S_UNI: state_nxt = S_ACC;
      S_ACC: begin
        if (cur_r[st_r] && (32'(st_r) < ns) && nfa_rvld_r) uni_nxt = uni_r | nfa_rdata_r;
        if (32'(st_r) == NFA_STATES - 1) begin
          state_nxt = S_EVAL;
        end else begin
          st_nxt = st_r + SB'(1);
          state_nxt = S_UNI;
        end
      end
      S_EVAL: begin
        if (32'(sym_r) >= nsym || uni_m == '0) begin
          nxt_we = 1'b1;
          state_nxt = S_NSYM;
        end else begin
          uni_nxt = uni_m;
          k_nxt = '0;
          state_nxt = S_SREAD;
        end
      end
      S_SREAD: begin
        if (k_r == count_r) begin
          nxt_we = 1'b1;
          if (32'(count_r) < DFA_STATES) begin
            sub_we = 1'b1;
            nxt_wdata = {1'b1, count_r[DW-1:0]};
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_NSYM;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sub_rdata_r[SW-1:0] == uni_r) begin
          nxt_we = 1'b1;
          nxt_wdata = {1'b1, k_r[DW-1:0]};
          state_nxt = S_NSYM;
        end else begin
          k_nxt = k_r + CW'(1);
          state_nxt = S_SREAD;
        end
      end
      S_NSYM: begin
        st_nxt = '0;
        uni_nxt = '0;
        if (32'(sym_r) == SYMBOLS - 1) begin
          wp_nxt = wp_r + CW'(1);
          state_nxt = S_FETCH;
        end else begin
          sym_nxt = sym_r + YB'(1);
          state_nxt = S_UNI;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      wp_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wp_r <= wp_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    sym_in_r <= sym_in_nxt;
    idx_r <= idx_nxt;
    k_r <= k_nxt;
    cur_r <= cur_nxt;
    uni_r <= uni_nxt;
    st_r <= st_nxt;
    sym_r <= sym_nxt;
    o_status_r <= o_status_nxt;
    o_nv_r <= o_nv_nxt;
    o_fin_r <= o_fin_nxt;
    o_ni_r <= o_ni_nxt;
    o_sm_r <= o_sm_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = o_status_r;
  assign out_state_count = 9'(count_r);
  assign out_next_valid = o_nv_r;
  assign out_next_index = o_ni_r;
  assign out_subset_mask = o_sm_r;
  assign out_is_final = o_fin_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DFA_STATES)
    else $error("dfa count above store depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_READ && state_r != S_RDOUT) |-> wp_r <= count_r)
    else $error("work pointer passed dfa count");

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !ov_r)
    else $error("result shown while item at work");

  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_operation == nfa2dfa_pkg::OP_BUILD) |=> (state_r == S_INIT && !in_ready))
    else $error("build transfer did not start sequencer");

endmodule
`default_nettype wire
